FILE: design/fip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_pkg
// shared types and constants of the integer power block
// ----------------------------------------------------------------------------
package fip_pkg;

    localparam int unsigned EXPONENT_BITS_DEF = 32;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;

    // significand product / quotient width and working exponent width
    localparam int unsigned SIG_W     = 106;
    localparam int unsigned XP_W      = 16;
    localparam int unsigned MUL_CHUNK = 14;
    localparam int unsigned MUL_STEPS = (53 + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int unsigned QUO_BITS  = 56;

    typedef enum logic [0:0] {
        FPU_MUL   = 1'b0,
        FPU_RECIP = 1'b1
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_ctl_t;

endpackage

FILE: design/fip_operand_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_operand_if
// request channel carrying base and integer exponent
// ----------------------------------------------------------------------------
interface fip_operand_if #(
    parameter int unsigned EXPONENT_BITS = fip_pkg::EXPONENT_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic [63:0]                     base_bits;
    logic signed [EXPONENT_BITS-1:0] exponent;

    modport source (output valid, base_bits, exponent, input ready);
    modport sink   (input valid, base_bits, exponent, output ready);
endinterface

FILE: design/fip_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_result_if
// result channel carrying the binary64 power
// ----------------------------------------------------------------------------
interface fip_result_if ();
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;

    modport source (output valid, result_bits, input ready);
    modport sink   (input valid, result_bits, output ready);
endinterface

FILE: design/fip_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fip_fpu
// multi-cycle binary64 multiply and reciprocal, round to nearest even
// ----------------------------------------------------------------------------
module fip_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  fip_pkg::fpu_ctl_t ctl,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic              done,
    output logic [63:0]       y
);
    import fip_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_MUL   = 6'b000010,
        F_DNORM = 6'b000100,
        F_DIV   = 6'b001000,
        F_NORM  = 6'b010000,
        F_ROUND = 6'b100000
    } fstate_t;

    fstate_t                 state_reg, state_next;
    logic [SIG_W-1:0]        sig_reg, sig_next;
    logic signed [XP_W-1:0]  x_reg, x_next;
    logic                    sticky_reg, sticky_next;
    logic                    sign_reg, sign_next;
    logic [52:0]             ma_reg, ma_next;
    logic [55:0]             mb_reg, mb_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic [53:0]             rem_reg, rem_next;
    logic [QUO_BITS-1:0]     q_reg, q_next;
    logic [63:0]             y_reg, y_next;
    logic                    done_reg, done_next;

    // operand decode
    logic [10:0]            ea, eb;
    logic                   a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [52:0]            ma, mb;
    logic signed [XP_W-1:0] xa, xb;

    // datapath
    logic [66:0]            pp;
    logic                   ge;
    logic [53:0]            dif;
    logic [QUO_BITS-1:0]    q_fin;
    logic signed [XP_W-1:0] be, dsh;
    logic [6:0]             d;
    logic [SIG_W-1:0]       sh, lost_mask;
    logic                   lost, rnd, g, st;
    logic [10:0]            efield;
    logic [62:0]            packed_mag;

    assign ea     = a[62:52];
    assign eb     = b[62:52];
    assign a_nan  = (ea == 11'h7FF) && (a[51:0] != 52'd0);
    assign b_nan  = (eb == 11'h7FF) && (b[51:0] != 52'd0);
    assign a_inf  = (ea == 11'h7FF) && (a[51:0] == 52'd0);
    assign b_inf  = (eb == 11'h7FF) && (b[51:0] == 52'd0);
    assign a_zero = (a[62:0] == 63'd0);
    assign b_zero = (b[62:0] == 63'd0);
    assign ma     = {ea != 11'd0, a[51:0]};
    assign mb     = {eb != 11'd0, b[51:0]};
    assign xa     = $signed({5'd0, ((ea == 11'd0) ? 11'd1 : ea)}) - 16'sd1075;
    assign xb     = $signed({5'd0, ((eb == 11'd0) ? 11'd1 : eb)}) - 16'sd1075;

    assign pp     = ma_reg * mb_reg[55:42];
    assign ge     = (rem_reg >= {1'b0, ma_reg});
    assign dif    = ge ? (rem_reg - {1'b0, ma_reg}) : rem_reg;
    assign q_fin  = {q_reg[QUO_BITS-2:0], ge};

    // rounding and packing
    always_comb
    begin
        be  = x_reg + 16'sd1128;
        dsh = 16'sd1 - be;
        if (be >= 16'sd1)
            d = 7'd0;
        else if (dsh > 16'sd107)
            d = 7'd107;
        else
            d = dsh[6:0];
        lost_mask  = ~({SIG_W{1'b1}} << d);
        lost       = |(sig_reg & lost_mask);
        sh         = sig_reg >> d;
        efield     = (be >= 16'sd1) ? be[10:0] : 11'd0;
        g          = sh[52];
        st         = (|sh[51:0]) | lost | sticky_reg;
        rnd        = g & (st | sh[53]);
        packed_mag = {efield, sh[104:53]} + {62'd0, rnd};
    end

    always_comb
    begin
        state_next  = state_reg;
        sig_next    = sig_reg;
        x_next      = x_reg;
        sticky_next = sticky_reg;
        sign_next   = sign_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        y_next      = y_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (ctl.start)
                begin
                    if (ctl.op == FPU_MUL)
                    begin
                        sign_next = a[63] ^ b[63];
                        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                        begin
                            y_next    = CANON_NAN;
                            done_next = 1'b1;
                        end
                        else if (a_inf || b_inf)
                        begin
                            y_next    = {a[63] ^ b[63], INF_MAG};
                            done_next = 1'b1;
                        end
                        else if (a_zero || b_zero)
                        begin
                            y_next    = {a[63] ^ b[63], 63'd0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ma_next    = ma;
                            mb_next    = {3'd0, mb};
                            sig_next   = '0;
                            x_next     = xa + xb;
                            cnt_next   = '0;
                            state_next = F_MUL;
                        end
                    end
                    else
                    begin
                        sign_next = b[63];
                        if (b_nan)
                        begin
                            y_next    = CANON_NAN;
                            done_next = 1'b1;
                        end
                        else if (b_inf)
                        begin
                            y_next    = {b[63], 63'd0};
                            done_next = 1'b1;
                        end
                        else if (b_zero)
                        begin
                            y_next    = {b[63], INF_MAG};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ma_next    = mb;
                            x_next     = xb;
                            state_next = F_DNORM;
                        end
                    end
                end
            end
            F_MUL:
            begin
                // top chunk of the multiplier first, accumulator shifts up
                sig_next = {sig_reg[SIG_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}}
                         + {{(SIG_W-67){1'b0}}, pp};
                mb_next  = {mb_reg[55-MUL_CHUNK:0], {MUL_CHUNK{1'b0}}};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MUL_STEPS - 1))
                begin
                    sticky_next = 1'b0;
                    state_next  = F_NORM;
                end
            end
            F_DNORM:
            begin
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    x_next  = x_reg - 16'sd1;
                end
                else
                begin
                    rem_next   = 54'd1 << 52;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                q_next   = q_fin;
                rem_next = {dif[52:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(QUO_BITS - 1))
                begin
                    sig_next    = {q_fin, {(SIG_W-QUO_BITS){1'b0}}};
                    sticky_next = (dif != 54'd0);
                    x_next      = -16'sd157 - x_reg;
                    state_next  = F_NORM;
                end
            end
            F_NORM:
            begin
                if (sig_reg[SIG_W-1 -: 16] == 16'd0)
                begin
                    sig_next = {sig_reg[SIG_W-17:0], 16'd0};
                    x_next   = x_reg - 16'sd16;
                end
                else if (!sig_reg[SIG_W-1])
                begin
                    sig_next = {sig_reg[SIG_W-2:0], 1'b0};
                    x_next   = x_reg - 16'sd1;
                end
                else
                begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND:
            begin
                if (be >= 16'sd2047)
                    y_next = {sign_reg, INF_MAG};
                else
                    y_next = {sign_reg, packed_mag};
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg    <= sig_next;
        x_reg      <= x_next;
        sticky_reg <= sticky_next;
        sign_reg   <= sign_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        y_reg      <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

FILE: design/float_integer_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_integer_power
// binary64 base raised to a signed integer power by square-and-multiply
// ----------------------------------------------------------------------------
//  channel   dir   payload                          request taken when
//  operand   sink  base_bits[63:0], exponent[N-1:0] valid & ready
//  result    src   result_bits[63:0]                valid & ready
//
//  one request at a time; ready is high only while the sequencer is idle
//  per request: a reciprocal first for a negative exponent (a subnormal divisor adds
//    normalising steps), then up to 2*N multiplies, each normalised and rounded
//  all arithmetic goes through the single shared multiply/reciprocal unit
//  reset clears the sequencer and the output valid; no clearing pass
//  a stalled result holds in the output register until taken
// ----------------------------------------------------------------------------
module float_integer_power #(
    parameter int unsigned EXPONENT_BITS = fip_pkg::EXPONENT_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    fip_operand_if.sink  operand,
    fip_result_if.source result
);
    import fip_pkg::*;

    typedef enum logic [5:0] {
        T_IDLE  = 6'b000001,
        T_RWAIT = 6'b000010,
        T_STEP  = 6'b000100,
        T_AWAIT = 6'b001000,
        T_SWAIT = 6'b010000,
        T_DONE  = 6'b100000
    } tstate_t;

    tstate_t                  state_reg, state_next;
    logic [63:0]              acc_reg, acc_next;
    logic [63:0]              sq_reg, sq_next;
    logic [EXPONENT_BITS-1:0] mag_reg, mag_next;
    logic                     out_valid_reg, out_valid_next;
    logic [63:0]              out_reg, out_next;

    fpu_ctl_t                 fpu_ctl;
    logic [63:0]              fpu_a, fpu_b, fpu_y;
    logic                     fpu_done;

    logic                     take;
    logic                     neg;
    logic [EXPONENT_BITS-1:0] e_raw, mag_in;
    logic [EXPONENT_BITS-1:0] mag_shr;

    assign take    = operand.valid && operand.ready;
    assign e_raw   = operand.exponent;
    assign neg     = e_raw[EXPONENT_BITS-1];
    // most negative exponent wraps to its own pattern, read as 2^(N-1)
    assign mag_in  = neg ? (~e_raw + {{(EXPONENT_BITS-1){1'b0}}, 1'b1}) : e_raw;
    assign mag_shr = mag_reg >> 1;

    // shared unit operands: accumulator only for the multiply-in step
    assign fpu_a = ((state_reg == T_STEP) && mag_reg[0]) ? acc_reg : sq_reg;
    assign fpu_b = (state_reg == T_IDLE) ? operand.base_bits : sq_reg;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        fpu_ctl.start  = 1'b0;
        fpu_ctl.op     = FPU_MUL;

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (take)
                begin
                    acc_next = ONE_BITS;
                    sq_next  = operand.base_bits;
                    mag_next = mag_in;
                    if ((operand.base_bits[62:0] == 63'd0) && (e_raw == '0))
                    begin
                        // zero to the zero
                        acc_next   = CANON_NAN;
                        state_next = T_DONE;
                    end
                    else if (neg)
                    begin
                        fpu_ctl.start = 1'b1;
                        fpu_ctl.op    = FPU_RECIP;
                        state_next    = T_RWAIT;
                    end
                    else
                    begin
                        state_next = T_STEP;
                    end
                end
            end
            T_RWAIT:
            begin
                if (fpu_done)
                begin
                    sq_next    = fpu_y;
                    state_next = T_STEP;
                end
            end
            T_STEP:
            begin
                if (mag_reg == '0)
                begin
                    state_next = T_DONE;
                end
                else if (mag_reg[0])
                begin
                    fpu_ctl.start = 1'b1;
                    state_next    = T_AWAIT;
                end
                else
                begin
                    // even bit: only square, remaining magnitude is nonzero
                    fpu_ctl.start = 1'b1;
                    mag_next      = mag_shr;
                    state_next    = T_SWAIT;
                end
            end
            T_AWAIT:
            begin
                if (fpu_done)
                begin
                    acc_next = fpu_y;
                    mag_next = mag_shr;
                    if (mag_shr != '0)
                    begin
                        fpu_ctl.start = 1'b1;
                        state_next    = T_SWAIT;
                    end
                    else
                    begin
                        state_next = T_DONE;
                    end
                end
            end
            T_SWAIT:
            begin
                if (fpu_done)
                begin
                    sq_next    = fpu_y;
                    state_next = T_STEP;
                end
            end
            T_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        mag_reg <= mag_next;
        out_reg <= out_next;
    end

    fip_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fpu_ctl),
        .a     (fpu_a),
        .b     (fpu_b),
        .done  (fpu_done),
        .y     (fpu_y)
    );

    assign operand.ready      = (state_reg == T_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.result_bits = out_reg;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the binary64 integer power block
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a bursty driver, a monitor compares each
// returned power with a double-precision square-and-multiply prediction.
// directed corner requests come first, then random requests. the receiver
// stalls on its own pattern, holds off once for a long stretch, and the
// driver pauses once until every outstanding power has come back
// ----------------------------------------------------------------------------
module tb;

    import fip_pkg::*;

    localparam int unsigned EXP_W      = 32;
    localparam int          N_RANDOM   = 430;
    localparam int          DRAIN_AT   = 250;   // requests sent before the pause
    localparam int          HOLD_AT    = 100;   // requests sent before the long hold
    localparam int          HOLD_LEN   = 3000;  // cycles of the long hold
    localparam int          SETTLE     = 1500;

    typedef struct {
        logic [63:0]             base;
        logic signed [EXP_W-1:0] expo;
    } power_req_t;

    logic clk;
    logic rst_n;

    fip_operand_if #(.EXPONENT_BITS(EXP_W)) op_if ();
    fip_result_if                           res_if ();

    float_integer_power #(
        .EXPONENT_BITS(EXP_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .operand(op_if),
        .result (res_if)
    );

    power_req_t  pending_q[$];     // requests not yet offered
    logic [63:0] power_q[$];       // predicted powers still to arrive
    bit          stimulus_loaded;
    bit          hold_long;
    bit          draining;
    bit          drain_done;
    int          sent;
    int          mismatches = 0;
    int          burst_left;
    int          gap_left;
    int          ready_mode;
    int          mode_cycles;

    // ------------------------------------------------------------------------
    // prediction: reals are binary64, every operation rounds nearest-even
    // ------------------------------------------------------------------------
    function automatic logic [63:0] int_power(logic [63:0] b, logic signed [EXP_W-1:0] e);
        logic [EXP_W-1:0] mag;
        real              base_r;
        real              acc;
        real              sq;
        logic [63:0]      r;
        // zero to the zero is a quiet nan
        if (b[62:0] == 63'd0 && e == 0)
            return CANON_NAN;
        if (e < 0)
        begin
            mag = ~e + EXP_W'(1);   // most negative exponent gives 2^(n-1)
            // the reciprocal of a signed zero is the infinity of that sign
            if (b[62:0] == 63'd0)
                base_r = $bitstoreal({b[63], INF_MAG});
            else
                base_r = 1.0 / $bitstoreal(b);
        end
        else
        begin
            mag    = e;
            base_r = $bitstoreal(b);
        end
        acc = 1.0;
        sq  = base_r;
        while (mag != 0)
        begin
            if (mag[0])
                acc = acc * sq;
            mag = mag >> 1;
            if (mag != 0)
                sq = sq * sq;
        end
        r = $realtobits(acc);
        // every nan leaves as the canonical one
        if (r[62:0] > INF_MAG)
            r = CANON_NAN;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock and the single reset
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // stimulus: directed corners, then random requests
    // ------------------------------------------------------------------------
    initial
    begin
        power_req_t  req;
        logic [63:0] b;
        logic [31:0] e;
        logic [63:0] corner_base[12];
        logic [31:0] corner_expo[12];
        corner_base = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                        64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                        64'h7FF8_0000_0000_0001, 64'h0000_0000_0000_0001,
                        64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
                        64'hBFF0_0000_0000_0000, 64'h4000_0000_0000_0000,
                        64'h3FF0_0000_0000_0001, 64'hC000_0000_0000_0000};
        corner_expo = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'd2, 32'd3, 32'hFFFF_FFFE,
                        32'd1023, 32'hFFFF_FC00, 32'd1075, 32'd7};

        // zero to the zero, both signs
        pending_q.push_back('{64'h0000_0000_0000_0000, 32'sd0});
        pending_q.push_back('{64'h8000_0000_0000_0000, 32'sd0});
        // zero to negative powers, odd and even
        pending_q.push_back('{64'h8000_0000_0000_0000, -32'sd3});
        pending_q.push_back('{64'h8000_0000_0000_0000, -32'sd2});
        pending_q.push_back('{64'h0000_0000_0000_0000, 32'sh8000_0000});
        // infinities to negative powers give signed zeros
        pending_q.push_back('{64'hFFF0_0000_0000_0000, -32'sd1});
        pending_q.push_back('{64'h7FF0_0000_0000_0000, -32'sd5});
        // exponent zero on infinity and nan gives one; then a nan squared
        pending_q.push_back('{64'hFFF0_0000_0000_0000, 32'sd0});
        pending_q.push_back('{64'h7FF8_0000_0000_0001, 32'sd0});
        pending_q.push_back('{64'hFFF0_0000_0000_0123, 32'sd2});
        // overflow, underflow and the subnormal range
        pending_q.push_back('{64'h7FEF_FFFF_FFFF_FFFF, 32'sd2});
        pending_q.push_back('{64'h0000_0000_0000_0001, 32'sd1});
        pending_q.push_back('{64'h0000_0000_0000_0001, -32'sd1});
        pending_q.push_back('{64'h000F_FFFF_FFFF_FFFF, -32'sd1});
        pending_q.push_back('{64'h3FE0_0000_0000_0000, 32'sd1074});
        pending_q.push_back('{64'h3FE0_0000_0000_0000, 32'sd1075});
        // extremes of the exponent field
        pending_q.push_back('{64'h3FF0_0000_0000_0001, 32'sh7FFF_FFFF});
        pending_q.push_back('{64'hBFF0_0000_0000_0000, 32'sh7FFF_FFFF});
        pending_q.push_back('{64'hBFF0_0000_0000_0000, 32'sh8000_0000});
        pending_q.push_back('{64'hBFEF_FFFF_FFFF_FFFF, 32'sh8000_0001});
        pending_q.push_back('{64'h4009_21FB_5444_2D18, -32'sd7});
        pending_q.push_back('{64'hFFFF_FFFF_FFFF_FFFF, -32'sd1});

        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    b = {$urandom, $urandom};
                2:       b = corner_base[$urandom_range(0, 11)];
                3:       b = {$urandom_range(0, 1) == 1, 11'd0,
                              20'($urandom_range(0, 20'hFFFFF)), $urandom};
                default: b = {$urandom_range(0, 1) == 1, 11'd1023 + 11'($urandom_range(0, 8)) - 11'd4,
                              20'($urandom), $urandom};
            endcase
            case ($urandom_range(0, 9))
                0, 1:    e = $urandom;
                2:       e = corner_expo[$urandom_range(0, 11)];
                3:       e = 32'($urandom_range(0, 4000)) - 32'd2000;
                default: e = 32'($urandom_range(0, 80)) - 32'd40;
            endcase
            req.base = b;
            req.expo = e;
            pending_q.push_back(req);
        end
        stimulus_loaded = 1'b1;
    end

    // ------------------------------------------------------------------------
    // driver: bursts of requests with random gaps, one pause to drain
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_if.valid <= 1'b0;
            burst_left  <= 1;
            gap_left    <= 0;
            draining    <= 1'b0;
            drain_done  <= 1'b0;
            sent        <= 0;
        end
        else
        begin
            power_req_t nxt;
            bit         taken;
            int         sent_now;
            taken    = op_if.valid && op_if.ready;
            sent_now = sent;
            if (taken)
            begin
                power_q.push_back(int_power(op_if.base_bits, op_if.exponent));
                sent_now = sent + 1;
                sent     <= sent_now;
            end

            // pause once until every outstanding power has come back
            if (taken && sent_now == DRAIN_AT && !drain_done)
            begin
                draining   <= 1'b1;
                drain_done <= 1'b1;
            end
            else if (draining && power_q.size() == 0)
                draining <= 1'b0;

            if (op_if.valid && !taken)
                ;   // hold the offered request
            else if (draining || (taken && sent_now == DRAIN_AT && !drain_done))
                op_if.valid <= 1'b0;
            else if (gap_left > 0)
            begin
                op_if.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end
            else if (stimulus_loaded && pending_q.size() > 0)
            begin
                nxt = pending_q.pop_front();
                op_if.valid     <= 1'b1;
                op_if.base_bits <= nxt.base;
                op_if.exponent  <= nxt.expo;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                op_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready pattern changes mode every so often
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            ready_mode   <= 0;
            mode_cycles  <= 0;
        end
        else
        begin
            if (mode_cycles >= 1500)
            begin
                mode_cycles <= 0;
                ready_mode  <= $urandom_range(0, 2);
            end
            else
                mode_cycles <= mode_cycles + 1;

            if (hold_long)
                res_if.ready <= 1'b0;
            else
                case (ready_mode)
                    0:       res_if.ready <= 1'b1;                    // no stalls
                    1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // long hold-off: the output register fills and the input stalls
    initial
    begin
        hold_long = 1'b0;
        while (sent < HOLD_AT)
            @(posedge clk);
        hold_long <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_long <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // monitor: compare each returned power with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (power_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected power %h", res_if.result_bits);
            end
            else
            begin
                want = power_q.pop_front();
                if (res_if.result_bits !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_bits mismatch: expected %h actual %h",
                                 want, res_if.result_bits);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------------
    initial
    begin
        wait (stimulus_loaded);
        while (pending_q.size() != 0 || op_if.valid !== 1'b0 || power_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && power_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #60ms;
        $display("status: fail");
        $finish;
    end

endmodule
